[sv/ddm_pkg.sv]
// Shared types and constants of the descriptor distance match unit.
// No dependencies.
package ddm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 40;
  localparam int SQ_W     = 32;
  localparam int LABEL_W  = 6;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 64;

  localparam logic [SUM_W-1:0] SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] THRESH_RESET = 40'd106542033;  // 0.315^2 in Q.30

  localparam logic [1:0] CMD_STORE_ELEM  = 2'd0;
  localparam logic [1:0] CMD_STORE_LABEL = 2'd1;
  localparam logic [1:0] CMD_QUERY       = 2'd2;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_THRESHOLD   = 1'b1;

  typedef struct packed {
    logic [6:0]       entry_count;
    logic [SUM_W-1:0] threshold_squared;
  } cfg_t;

  typedef struct packed {
    logic issue;  // read of one entry presented to the memories this cycle
    logic live;   // that entry's sum holds data from this query
  } acc_req_t;

endpackage

[sv/descriptor_distance_match_unit.sv]
// Descriptor distance match unit. Store words are taken back to back while the unit is idle.
// A query word with an element in range holds the input off through an accumulate pass over
// every entry and a drain of the accumulator, so query words are not taken back to back.
// The last query word adds a scan of at most min(entry_count, TABLE_DEPTH) entries, one entry
// per cycle until a hit, then loads the result in the put state, which waits out a stalled word.
// Synchronous reset clears control and sums at once; descriptor and label memories are not cleared.
module descriptor_distance_match_unit #(
  parameter int TABLE_DEPTH       = 64,
  parameter int DESCRIPTOR_LENGTH = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ddm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ddm_pkg::PDATA_W-1:0]  pwdata,
  output logic [ddm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [5:0]                   entry,
  input  logic [6:0]                   element,
  input  logic signed [15:0]           sample,
  input  logic [5:0]                   label_value,
  input  logic                         last_element,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [5:0]                   match_entry,
  output logic [5:0]                   match_label
);

  localparam int IW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW = DESCRIPTOR_LENGTH > 1 ? $clog2(DESCRIPTOR_LENGTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DD = TABLE_DEPTH * DESCRIPTOR_LENGTH;
  localparam int AW = DD > 1 ? $clog2(DD) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_PUT   = 3'd4;

  ddm_pkg::cfg_t     cfg;
  ddm_pkg::acc_req_t acc_req;

  logic [2:0]             state;
  logic                   in_acc;
  logic                   entry_ok;
  logic                   elem_ok;
  logic [IW-1:0]          entry_idx;
  logic [EW-1:0]          elem_idx;

  logic [ddm_pkg::SAMPLE_W-1:0] q_sample;
  logic [EW-1:0]                q_elem;
  logic                         q_last;
  logic [IW-1:0]                acc_idx;
  logic [CW-1:0]                scan_cnt;
  logic [CW-1:0]                cnt_eff;
  logic                         scan_issue;
  logic                         cmp_vld;
  logic [IW-1:0]                cmp_idx;
  logic                         cmp_last;
  logic                         hit;
  logic [ddm_pkg::SUM_W-1:0]    cmp_sum;
  logic [TABLE_DEPTH-1:0]       live;

  logic                         res_found;
  logic [5:0]                   res_entry;
  logic [5:0]                   res_label;

  logic                         desc_we;
  logic [AW-1:0]                desc_waddr;
  logic [AW-1:0]                desc_raddr;
  logic [ddm_pkg::SAMPLE_W-1:0] desc_rdata;
  logic                         lbl_we;
  logic [ddm_pkg::LABEL_W-1:0]  lbl_rdata;
  logic [IW-1:0]                sum_raddr;
  logic [ddm_pkg::SUM_W-1:0]    sum_rdata;
  logic                         acc_wr_en;
  logic [IW-1:0]                acc_wr_idx;
  logic [ddm_pkg::SUM_W-1:0]    acc_wr_sum;
  logic                         acc_busy;

  ddm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign entry_ok  = 32'(entry) < TABLE_DEPTH;
  assign elem_ok   = 32'(element) < DESCRIPTOR_LENGTH;
  assign entry_idx = IW'(entry);
  assign elem_idx  = EW'(element);

  assign desc_we    = in_acc && (command == ddm_pkg::CMD_STORE_ELEM) && entry_ok && elem_ok;
  assign desc_waddr = AW'(32'(entry_idx) * DESCRIPTOR_LENGTH + 32'(elem_idx));
  assign desc_raddr = AW'(32'(acc_idx) * DESCRIPTOR_LENGTH + 32'(q_elem));
  assign lbl_we     = in_acc && (command == ddm_pkg::CMD_STORE_LABEL) && entry_ok;
  assign sum_raddr  = (state == ST_ACC) ? acc_idx : scan_cnt[IW-1:0];

  assign cnt_eff    = (32'(cfg.entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                            : CW'(cfg.entry_count);
  assign scan_issue = (state == ST_SCAN) && (scan_cnt < cnt_eff);
  assign cmp_sum    = live[cmp_idx] ? sum_rdata : '0;
  assign hit        = cmp_sum < cfg.threshold_squared;
  assign cmp_last   = (32'(cmp_idx) + 32'd1) == 32'(cnt_eff);

  assign acc_req.issue = (state == ST_ACC);
  assign acc_req.live  = live[acc_idx];

  ddm_ram #(.WIDTH(ddm_pkg::SAMPLE_W), .DEPTH(DD)) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (desc_waddr),
    .wdata (sample),
    .raddr (desc_raddr),
    .rdata (desc_rdata)
  );

  ddm_ram #(.WIDTH(ddm_pkg::LABEL_W), .DEPTH(TABLE_DEPTH)) u_label_ram (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (entry_idx),
    .wdata (label_value),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (lbl_rdata)
  );

  ddm_ram #(.WIDTH(ddm_pkg::SUM_W), .DEPTH(TABLE_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (acc_wr_en),
    .waddr (acc_wr_idx),
    .wdata (acc_wr_sum),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  ddm_sq_acc #(.IW(IW)) u_sq_acc (
    .clk      (clk),
    .rst      (rst),
    .req      (acc_req),
    .req_idx  (acc_idx),
    .q_sample (q_sample),
    .s_sample (desc_rdata),
    .old_sum  (sum_rdata),
    .wr_en    (acc_wr_en),
    .wr_idx   (acc_wr_idx),
    .wr_sum   (acc_wr_sum),
    .busy     (acc_busy)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      live      <= '0;
      out_valid <= 1'b0;
      cmp_vld   <= 1'b0;
      acc_idx   <= '0;
      scan_cnt  <= '0;
    end else begin
      cmp_vld <= scan_issue;
      // a word loaded from the put state replaces the one leaving
      if (out_valid && !out_stall && (state != ST_PUT)) begin
        out_valid <= 1'b0;
      end
      if (acc_wr_en) begin
        live[acc_wr_idx] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && (command == ddm_pkg::CMD_QUERY)) begin
            acc_idx  <= '0;
            scan_cnt <= '0;
            if (elem_ok) begin
              state <= ST_ACC;
            end else if (last_element) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_ACC: begin
          acc_idx <= acc_idx + IW'(1);
          if (acc_idx == IW'(TABLE_DEPTH - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!acc_busy) begin
            scan_cnt <= '0;
            state    <= q_last ? ST_SCAN : ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          if (cnt_eff == '0) begin
            state <= ST_PUT;
          end else if (cmp_vld && (hit || cmp_last)) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            live      <= '0;  // all sums back to zero
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_idx <= scan_cnt[IW-1:0];
    if (in_acc && (command == ddm_pkg::CMD_QUERY)) begin
      q_sample <= sample;
      q_elem   <= elem_idx;
      q_last   <= last_element;
    end
    if (state == ST_SCAN) begin
      if (cnt_eff == '0 || (cmp_vld && !hit && cmp_last)) begin
        res_found <= 1'b0;
        res_entry <= '0;
        res_label <= '0;
      end else if (cmp_vld && hit) begin
        res_found <= 1'b1;
        res_entry <= 6'(cmp_idx);
        res_label <= lbl_rdata;
      end
    end
    if (state == ST_PUT && (!out_valid || !out_stall)) begin
      found       <= res_found;
      match_entry <= res_entry;
      match_label <= res_label;
    end
  end

`ifndef SYNTHESIS
  a_wr_in_pass: assert property (@(posedge clk) disable iff (rst)
    acc_wr_en |-> (state == ST_ACC || state == ST_DRAIN))
    else $error("sum write outside accumulate pass");

  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !acc_busy)
    else $error("scan started with accumulator in flight");

  a_result_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_PUT))
    else $error("result word loaded outside put state");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_entry == 6'd0 && match_label == 6'd0))
    else $error("no-match word carries nonzero entry or label");
`endif

endmodule

[sv/ddm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ddm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ddm_regs.sv]
// APB register file: entry count and squared threshold.
// Uses ddm_pkg.
module ddm_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ddm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ddm_pkg::PDATA_W-1:0]  pwdata,
  output logic [ddm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output ddm_pkg::cfg_t                cfg
);

  logic wr;
  logic sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[3];  // registers sit 8 bytes apart

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_count       <= '0;
      cfg.threshold_squared <= ddm_pkg::THRESH_RESET;
    end else if (wr) begin
      if (sel == ddm_pkg::REG_THRESHOLD) begin
        cfg.threshold_squared <= pwdata[ddm_pkg::SUM_W-1:0];
      end else begin
        cfg.entry_count <= pwdata[6:0];
      end
    end
  end

  always_comb begin
    if (sel == ddm_pkg::REG_THRESHOLD) begin
      prdata = {{(ddm_pkg::PDATA_W-ddm_pkg::SUM_W){1'b0}}, cfg.threshold_squared};
    end else begin
      prdata = {{(ddm_pkg::PDATA_W-7){1'b0}}, cfg.entry_count};
    end
  end

endmodule

[sv/ddm_sq_acc.sv]
// Shared squared-difference accumulator: one entry per cycle, two stages.
// Uses ddm_pkg; fed from the descriptor and sum memories in the top level.
module ddm_sq_acc #(
  parameter int IW = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ddm_pkg::acc_req_t                 req,
  input  logic [IW-1:0]                     req_idx,
  input  logic [ddm_pkg::SAMPLE_W-1:0]      q_sample,
  input  logic [ddm_pkg::SAMPLE_W-1:0]      s_sample,  // memory data, cycle after issue
  input  logic [ddm_pkg::SUM_W-1:0]         old_sum,   // memory data, cycle after issue
  output logic                              wr_en,
  output logic [IW-1:0]                     wr_idx,
  output logic [ddm_pkg::SUM_W-1:0]         wr_sum,
  output logic                              busy
);

  logic                         rd_vld;
  logic                         rd_live;
  logic [IW-1:0]                rd_idx;
  logic                         sq_vld;
  logic [IW-1:0]                sq_idx;
  logic [ddm_pkg::SQ_W-1:0]     sq;
  logic [ddm_pkg::SUM_W-1:0]    base;

  logic signed [ddm_pkg::SAMPLE_W:0] diff;
  logic signed [ddm_pkg::SAMPLE_W:0] mag_full;
  logic [ddm_pkg::SAMPLE_W-1:0]      mag;
  logic [ddm_pkg::SQ_W-1:0]          sq_next;
  logic [ddm_pkg::SUM_W:0]           total;

  always_comb begin
    diff     = $signed({q_sample[ddm_pkg::SAMPLE_W-1], q_sample})
             - $signed({s_sample[ddm_pkg::SAMPLE_W-1], s_sample});
    mag_full = diff[ddm_pkg::SAMPLE_W] ? -diff : diff;
    mag      = mag_full[ddm_pkg::SAMPLE_W-1:0];
    sq_next  = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      sq_vld <= 1'b0;
    end else begin
      rd_vld <= req.issue;
      sq_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    rd_live <= req.live;
    rd_idx  <= req_idx;
    sq_idx  <= rd_idx;
    sq      <= sq_next;
    base    <= rd_live ? old_sum : '0;
  end

  // saturating add at 2^40 - 1
  assign total  = {1'b0, base} + {{(ddm_pkg::SUM_W+1-ddm_pkg::SQ_W){1'b0}}, sq};
  assign wr_sum = total[ddm_pkg::SUM_W] ? ddm_pkg::SUM_MAX : total[ddm_pkg::SUM_W-1:0];
  assign wr_en  = sq_vld;
  assign wr_idx = sq_idx;
  assign busy   = rd_vld || sq_vld;

endmodule

[sim/tb_descriptor_distance_match_unit.sv]
// Self-checking testbench for descriptor_distance_match_unit: stores, queries, APB setup.
// Needs ddm_pkg and the unit's RTL; carries its own squared-distance predictor.
module tb_descriptor_distance_match_unit;

  localparam int DEPTH = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT = 18;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_WORDS = 75;
  localparam int SAT_REPEATS = 260;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         entry;
    logic [6:0]         element;
    logic signed [15:0] sample;
    logic [5:0]         label_value;
    logic               last_element;
  } word_t;

  typedef struct packed {
    logic       found;
    logic [5:0] match_entry;
    logic [5:0] match_label;
  } match_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    word_t      w;
    bit         typed;
    match_t     res;
    logic [6:0] cnt;
    logic [ddm_pkg::SUM_W-1:0] thr;
  } row_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [ddm_pkg::PADDR_W-1:0] paddr;
  logic [ddm_pkg::PDATA_W-1:0] pwdata, prdata;
  logic in_valid, in_stall;
  logic [1:0] command;
  logic [5:0] entry;
  logic [6:0] element;
  logic signed [15:0] sample;
  logic [5:0] label_value;
  logic last_element;
  logic out_valid, out_stall, found;
  logic [5:0] match_entry, match_label;

  // matcher state as the block should hold it
  logic signed [15:0]        desc_mem [DEPTH][128];
  logic [5:0]                label_mem [DEPTH];
  logic [ddm_pkg::SUM_W-1:0] dist_sum [DEPTH];
  logic [6:0]                cfg_count;
  logic [ddm_pkg::SUM_W-1:0] cfg_thresh;

  match_t expected_matches [$];
  row_t   plan [$];
  bit     cur_typed;
  match_t cur_typed_res;
  bit     quiet, hold_req;
  int     mismatches;
  int unsigned cycle_count;

  descriptor_distance_match_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .entry(entry), .element(element), .sample(sample),
    .label_value(label_value), .last_element(last_element),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .match_entry(match_entry), .match_label(match_label)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endfunction

  // Returns 1 when the word yields a match report.
  function automatic bit advance_matcher(input word_t w, output match_t res);
    int q, d, lim, i;
    longint unsigned acc;
    res = '0;
    if (w.command == ddm_pkg::CMD_STORE_ELEM) begin
      desc_mem[w.entry][w.element] = w.sample;
      return 1'b0;
    end
    if (w.command == ddm_pkg::CMD_STORE_LABEL) begin
      label_mem[w.entry] = w.label_value;
      return 1'b0;
    end
    if (w.command != ddm_pkg::CMD_QUERY) return 1'b0;
    q = $signed(w.sample);
    for (i = 0; i < DEPTH; i++) begin
      d = q - int'(desc_mem[i][w.element]);
      acc = longint'(dist_sum[i]) + longint'(d) * longint'(d);
      dist_sum[i] = (acc > ddm_pkg::SUM_MAX) ? ddm_pkg::SUM_MAX : acc[ddm_pkg::SUM_W-1:0];
    end
    if (!w.last_element) return 1'b0;
    lim = (cfg_count > DEPTH) ? DEPTH : int'(cfg_count);
    for (i = 0; i < lim; i++) begin
      if (dist_sum[i] < cfg_thresh) begin
        res.found = 1'b1;
        res.match_entry = i[5:0];
        res.match_label = label_mem[i];
        break;
      end
    end
    for (i = 0; i < DEPTH; i++) dist_sum[i] = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    word_t  w;
    match_t predicted, got, want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        w = {command, entry, element, sample, label_value, last_element};
        if (advance_matcher(w, predicted))
          expected_matches.insert(expected_matches.size(),
                                  cur_typed ? cur_typed_res : predicted);
      end
      if (out_valid && !out_stall) begin
        got = {found, match_entry, match_label};
        if (expected_matches.size() == 0) begin
          note_mismatch($sformatf("unexpected result found=%0b entry=%0d label=%0d",
                                  got.found, got.match_entry, got.match_label));
        end else begin
          want = expected_matches.pop_front();
          if (got.found !== want.found || got.match_entry !== want.match_entry ||
              got.match_label !== want.match_label)
            note_mismatch($sformatf("exp found=%0b entry=%0d label=%0d, got %0b/%0d/%0d",
                                    want.found, want.match_entry, want.match_label,
                                    got.found, got.match_entry, got.match_label));
        end
      end
    end
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic word_t mk(input logic [1:0] c, input int ent, input int elem,
                               input int smp, input int lab, input bit fin);
    word_t w;
    w.command = c;
    w.entry = ent[5:0];
    w.element = elem[6:0];
    w.sample = smp[15:0];
    w.label_value = lab[5:0];
    w.last_element = fin;
    return w;
  endfunction

  // columns written for every entry up front; queries touch only these
  function automatic int qcol(input int k);
    case (k)
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 42;
      4: return 85;
      5: return 100;
      6: return 126;
      default: return 127;
    endcase
  endfunction

  function automatic int near(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic void add_word(input word_t w, input bit typed = 1'b0,
                                   input match_t res = '0);
    row_t r;
    r.kind = ROW_WORD;
    r.w = w;
    r.typed = typed;
    r.res = res;
    r.cnt = '0;
    r.thr = '0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_cfg(input logic [6:0] cnt,
                                  input logic [ddm_pkg::SUM_W-1:0] thr);
    row_t r;
    r.kind = ROW_CFG;
    r.w = '0;
    r.typed = 1'b0;
    r.res = '0;
    r.cnt = cnt;
    r.thr = thr;
    plan.insert(plan.size(), r);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input word_t w, input bit typed = 1'b0, input match_t res = '0);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    {command, entry, element, sample, label_value, last_element} = w;
    cur_typed = typed;
    cur_typed_res = res;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write, then read back over the same APB port
  task automatic write_reg(input logic idx, input logic [ddm_pkg::PDATA_W-1:0] val);
    logic [ddm_pkg::PDATA_W-1:0] got, want;
    in_valid = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ddm_pkg::PADDR_W'(idx) << 3;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    if (idx == ddm_pkg::REG_ENTRY_COUNT) begin
      cfg_count = val[6:0];
      want = ddm_pkg::PDATA_W'(cfg_count);
    end else begin
      cfg_thresh = val[ddm_pkg::SUM_W-1:0];
      want = ddm_pkg::PDATA_W'(cfg_thresh);
    end
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (idx == ddm_pkg::REG_ENTRY_COUNT ? (got[6:0] !== want[6:0])
                                        : (got[ddm_pkg::SUM_W-1:0] !== want[ddm_pkg::SUM_W-1:0]))
      note_mismatch($sformatf("register %0d readback exp %0h got %0h", idx, want, got));
  endtask

  task automatic set_config(input logic [6:0] cnt, input logic [ddm_pkg::SUM_W-1:0] thr);
    wait_drained();
    write_reg(ddm_pkg::REG_ENTRY_COUNT, ddm_pkg::PDATA_W'(cnt));
    write_reg(ddm_pkg::REG_THRESHOLD, ddm_pkg::PDATA_W'(thr));
  endtask

  // One random sequence; returns how many words count toward the phase.
  task automatic run_sequence(output int counted);
    int pick, n, k, tgt, src, dst, spread, col;
    counted = 0;
    pick = $urandom_range(99);
    if (pick < 65) begin
      // query aimed near one stored entry, sometimes broken up by a store
      tgt = $urandom_range(DEPTH - 1);
      n = $urandom_range(8, 1);
      case ($urandom_range(3))
        0: spread = 0;
        1: spread = 300;
        2: spread = 3000;
        default: spread = 40000;
      endcase
      for (k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0) begin
          send_word(mk(ddm_pkg::CMD_STORE_ELEM, $urandom_range(63), $urandom_range(127),
                       $urandom, $urandom_range(63), $urandom_range(1)));
          counted++;
        end
        col = qcol($urandom_range(7));
        send_word(mk(ddm_pkg::CMD_QUERY, $urandom_range(63), col,
                     near(desc_mem[tgt][col], spread), $urandom_range(63), k == n - 1));
        counted++;
      end
    end else if (pick < 80) begin
      // copy one entry onto another so several entries can match
      src = $urandom_range(DEPTH - 1);
      dst = $urandom_range(DEPTH - 1);
      for (k = 0; k < 8; k++) begin
        send_word(mk(ddm_pkg::CMD_STORE_ELEM, dst, qcol(k), near(desc_mem[src][qcol(k)], 200),
                     $urandom_range(63), $urandom_range(1)));
        counted++;
      end
      if ($urandom_range(1)) begin
        send_word(mk(ddm_pkg::CMD_STORE_LABEL, dst, $urandom_range(127), $urandom,
                     $urandom_range(63), $urandom_range(1)));
        counted++;
      end
    end else if (pick < 93) begin
      send_word(mk($urandom_range(1) ? ddm_pkg::CMD_STORE_ELEM : ddm_pkg::CMD_STORE_LABEL,
                   $urandom_range(63), $urandom_range(127), $urandom,
                   $urandom_range(63), $urandom_range(1)));
      counted++;
    end else if (pick < 97) begin
      send_word(mk(CMD_UNUSED, $urandom_range(63), $urandom_range(127), $urandom,
                   $urandom_range(63), $urandom_range(1)));
    end else begin
      send_word(mk(ddm_pkg::CMD_QUERY, $urandom_range(63), qcol($urandom_range(7)), $urandom,
                   $urandom_range(63), $urandom_range(1)));
      counted++;
    end
  endtask

  initial begin
    int i, k, p, n, done;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    {command, entry, element, sample, label_value, last_element} = '0;
    cur_typed = 1'b0;
    cur_typed_res = '0;
    cfg_count = '0;
    cfg_thresh = ddm_pkg::THRESH_RESET;
    for (i = 0; i < DEPTH; i++) dist_sum[i] = '0;

    // directed rows; typed results only where obvious
    add_word(mk(ddm_pkg::CMD_QUERY, 0, 0, 0, 0, 1), 1'b1, '0);    // no entries after reset
    add_word(mk(CMD_UNUSED, 63, 127, -1, 63, 1));                 // ignored code
    add_word(mk(ddm_pkg::CMD_STORE_LABEL, 0, 0, 0, 42, 1));       // last flag ignored on store
    add_word(mk(ddm_pkg::CMD_STORE_ELEM, 0, 0, 32767, 0, 0));
    add_word(mk(ddm_pkg::CMD_STORE_ELEM, 63, 127, -32768, 0, 1));
    add_word(mk(ddm_pkg::CMD_STORE_LABEL, 63, 0, 0, 63, 0));
    add_word(mk(ddm_pkg::CMD_STORE_LABEL, 1, 0, 0, 0, 0));
    add_cfg(7'd64, ddm_pkg::THRESH_RESET);
    add_word(mk(ddm_pkg::CMD_QUERY, 0, 0, 32767, 0, 1), 1'b1, '{1'b1, 6'd0, 6'd42});
    add_word(mk(ddm_pkg::CMD_QUERY, 0, 127, 32767, 0, 0));       // same element twice
    add_word(mk(ddm_pkg::CMD_QUERY, 0, 127, 32767, 0, 1));
    add_cfg(7'd64, '0);
    add_word(mk(ddm_pkg::CMD_QUERY, 0, 0, 32767, 0, 1), 1'b1, '0);  // nothing below zero
    add_cfg(7'd127, ddm_pkg::SUM_MAX);                              // count clipped to depth
    add_word(mk(ddm_pkg::CMD_QUERY, 0, 1, -32768, 0, 1), 1'b1, '{1'b1, 6'd0, 6'd42});
    add_cfg(7'd0, ddm_pkg::SUM_MAX);
    add_word(mk(ddm_pkg::CMD_QUERY, 0, 126, 12345, 0, 1), 1'b1, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (k = 0; k < 8; k++)
      for (i = 0; i < DEPTH; i++)
        send_word(mk(ddm_pkg::CMD_STORE_ELEM, i, qcol(k), $urandom, $urandom_range(63),
                     $urandom_range(1)));
    for (i = 0; i < DEPTH; i++)
      send_word(mk(ddm_pkg::CMD_STORE_LABEL, i, $urandom_range(127), $urandom,
                   $urandom_range(63), $urandom_range(1)));

    foreach (plan[ri]) begin
      if (plan[ri].kind == ROW_CFG) set_config(plan[ri].cnt, plan[ri].thr);
      else send_word(plan[ri].w, plan[ri].typed, plan[ri].res);
    end

    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_config(7'd64, ddm_pkg::THRESH_RESET);
        1: set_config(7'd127, ddm_pkg::SUM_MAX);
        2: set_config(7'd17,
                      ddm_pkg::SUM_W'($urandom_range(32'd500000000, 32'd100000000)));
        3: set_config(7'd1, {8'($urandom_range(3)), 32'($urandom)});
        4: set_config(7'd0, '0);
        default: set_config(7'($urandom_range(63, 2)), {8'($urandom), 32'($urandom)});
      endcase
      quiet = (p == 2);
      if (p == 0) hold_req = 1'b1;
      if (p == 1) begin
        // drive entry 0 into saturation on element 0
        send_word(mk(ddm_pkg::CMD_STORE_ELEM, 0, 0, -32768, 0, 0));
        for (k = 0; k < SAT_REPEATS; k++)
          send_word(mk(ddm_pkg::CMD_QUERY, 0, 0, 32767, 0, k == SAT_REPEATS - 1));
      end
      done = 0;
      while (done < PHASE_WORDS) begin
        run_sequence(n);
        done += n;
      end
    end
    quiet = 1'b0;

    wait_drained();
    if (mismatches == 0 && expected_matches.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
